@@ rtl/rraf_pkg.sv @@
// Shared constants and types for the rounded rectangle alpha fill block.
`default_nettype none

package rraf_pkg;

    // Screen geometry; positions at or beyond these limits are never drawn
    localparam int unsigned COORD_W = 12;
    localparam logic [COORD_W:0] SCREEN_WIDTH  = 13'd4096;
    localparam logic [COORD_W:0] SCREEN_HEIGHT = 13'd4096;

    localparam int unsigned PIXEL_W    = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // Square root datapath: radicand, root and pipeline depth of the root unit
    localparam int unsigned SQ_W        = 24;
    localparam int unsigned ROOT_W      = 12;
    localparam int unsigned ROOT_STAGES = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECT_LEFT     = 3'd0,
        CFG_RECT_TOP      = 3'd1,
        CFG_RECT_WIDTH    = 3'd2,
        CFG_RECT_HEIGHT   = 3'd3,
        CFG_CORNER_RADIUS = 3'd4,
        CFG_FILL_COLOR    = 3'd5,
        CFG_FILL_ALPHA    = 3'd6,
        CFG_BORDER_MODE   = 3'd7
    } cfg_idx_t;

endpackage

`default_nettype wire

@@ rtl/rraf_if.sv @@
// Valid/ready channel interfaces: pixel input, pixel result and register writes.
`default_nettype none

interface rraf_in_if
    import rraf_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [COORD_W-1:0]   pixel_x;
    logic [COORD_W-1:0]   pixel_y;
    logic [PIXEL_W-1:0]   dst_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output dst_pixel,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input dst_pixel,
                    output ready);
endinterface

interface rraf_out_if
    import rraf_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [PIXEL_W-1:0]   new_pixel;
    logic                 covered;

    modport source (output valid, output new_pixel, output covered, input ready);
    modport sink   (input valid, input new_pixel, input covered, output ready);
endinterface

interface rraf_cfg_if
    import rraf_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/rraf_isqrt.sv @@
// Pipelined integer square root, several result digits per stage.
`default_nettype none

module rraf_isqrt
    import rraf_pkg::*;
(
    input  wire                 clk,
    input  wire                 en,
    input  wire  [SQ_W-1:0]     radicand,
    output logic [ROOT_W-1:0]   root
);

    localparam int unsigned STEPS_PER_STAGE = ROOT_W / ROOT_STAGES;
    localparam int unsigned RES_W           = SQ_W + 1;

    typedef struct packed {
        logic [SQ_W-1:0]  op;
        logic [RES_W-1:0] res;
    } sq_t;

    sq_t st_reg [ROOT_STAGES];

    // One digit of the shift-subtract root: try the next bit, keep it if it fits
    function automatic sq_t sqrt_step(input sq_t s, input int k);
        logic [RES_W-1:0] one;
        logic [RES_W-1:0] trial;
        sq_t              o;
        one   = RES_W'(1) << (2 * (int'(ROOT_W) - 1 - k));
        trial = s.res + one;
        o     = s;
        if ({1'b0, s.op} >= trial)
        begin
            o.op  = s.op - trial[SQ_W-1:0];
            o.res = s.res + (one << 1);
        end
        o.res = o.res >> 1;
        return o;
    endfunction

    for (genvar g = 0; g < ROOT_STAGES; g++)
    begin : g_stage
        sq_t v_in;
        sq_t v_next;

        if (g == 0)
        begin : g_first
            assign v_in = {radicand, RES_W'(0)};
        end
        else
        begin : g_rest
            assign v_in = st_reg[g-1];
        end

        always_comb
        begin
            v_next = v_in;
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                v_next = sqrt_step(v_next, g * STEPS_PER_STAGE + j);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g] <= v_next;
            end
        end
    end

    assign root = st_reg[ROOT_STAGES-1].res[ROOT_W-1:0];

endmodule

`default_nettype wire

@@ rtl/rounded_rect_alpha_fill.sv @@
// Top level: rounded rectangle coverage and alpha blend, one pixel per beat.
`default_nettype none

// Composites one pixel of a rounded rectangle per beat. Each input beat carries a
// screen position and the pixel already in the framebuffer; each output beat carries
// the pixel to store and a flag that says whether the shape touched it. The block is
// a 14-stage pipeline: a new pixel is taken every clock, and results leave in the
// order their pixels went in. The depth comes from the corner inset (radius
// clamp, two squarings, and a four-stage square root unit that settles three root
// bits per stage), the edge compares, and four blend passes, one per possible hit
// of a border pixel. The whole pipeline holds while a result waits on the output,
// so back-pressure costs throughput but never drops or repeats a beat. Registers are
// written through the configuration channel, which is ready whenever reset is
// released; write them only while no pixel is in flight. Neither the pixel channel
// nor the configuration channel takes a beat while reset is asserted. There is no
// clearing pass after reset.
module rounded_rect_alpha_fill
    import rraf_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    rraf_in_if.sink        pixel,
    rraf_out_if.source     result,
    rraf_cfg_if.sink       cfg
);

    localparam int unsigned ST_ROOT       = 3 + ROOT_STAGES;
    localparam int unsigned ST_EDGE       = ST_ROOT + 1;
    localparam int unsigned CARRY_N       = ST_EDGE + 1;
    localparam int unsigned BLEND_PASSES  = 4;
    localparam int unsigned LAT           = CARRY_N + BLEND_PASSES + 1;

    // Per-pixel data that rides alongside the inset computation
    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [12:0]        dy;
        logic [ROOT_W-1:0]  r;
        logic               row_ok;
        logic [PIXEL_W-1:0] dst;
    } carry_t;

    typedef struct packed {
        logic [2:0]         hits;
        logic [PIXEL_W-1:0] pix;
    } blend_t;

    // ---------------- configuration registers ----------------
    logic [12:0] rect_left_reg;
    logic [12:0] rect_top_reg;
    logic [12:0] rect_width_reg;
    logic [12:0] rect_height_reg;
    logic [11:0] corner_radius_reg;
    logic [23:0] fill_color_reg;
    logic [7:0]  fill_alpha_reg;
    logic        border_mode_reg;

    // Take register writes only once reset is released
    assign cfg.ready = rst_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg     <= '0;
            rect_top_reg      <= '0;
            rect_width_reg    <= '0;
            rect_height_reg   <= '0;
            corner_radius_reg <= '0;
            fill_color_reg    <= '0;
            fill_alpha_reg    <= 8'd255;
            border_mode_reg   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_RECT_LEFT:     rect_left_reg     <= cfg.data[12:0];
                CFG_RECT_TOP:      rect_top_reg      <= cfg.data[12:0];
                CFG_RECT_WIDTH:    rect_width_reg    <= cfg.data[12:0];
                CFG_RECT_HEIGHT:   rect_height_reg   <= cfg.data[12:0];
                CFG_CORNER_RADIUS: corner_radius_reg <= cfg.data[11:0];
                CFG_FILL_COLOR:    fill_color_reg    <= cfg.data[23:0];
                CFG_FILL_ALPHA:    fill_alpha_reg    <= cfg.data[7:0];
                CFG_BORDER_MODE:   border_mode_reg   <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    // Source terms of the blend depend only on registers. A pixel passes the inset and
    // edge stages before it reaches the blend stages, so these products are always current by then.
    logic [15:0] sa_r_reg;
    logic [15:0] sa_g_reg;
    logic [15:0] sa_b_reg;
    logic [7:0]  ia_reg;

    always_ff @(posedge clk)
    begin
        sa_r_reg <= 16'(fill_color_reg[23:16]) * 16'(fill_alpha_reg);
        sa_g_reg <= 16'(fill_color_reg[15:8])  * 16'(fill_alpha_reg);
        sa_b_reg <= 16'(fill_color_reg[7:0])   * 16'(fill_alpha_reg);
        ia_reg   <= 8'd255 - fill_alpha_reg;
    end

    // ---------------- pipeline control ----------------
    // Advance everything together unless a finished result is held at the output.
    logic            adv;
    logic [LAT-1:0]  vld_reg;

    assign adv         = !vld_reg[LAT-1] || result.ready;
    assign pixel.ready = adv && rst_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], pixel.valid};
        end
    end

    // ---------------- stage 0: clamp radius, locate the row ----------------
    logic [11:0] half_w;
    logic [11:0] half_h;
    logic [11:0] r_clamp;
    logic [13:0] dy_full;
    logic        on_screen;
    carry_t      carry_next;
    carry_t      carry_reg [CARRY_N];

    assign half_w = rect_width_reg[12:1];
    assign half_h = rect_height_reg[12:1];

    always_comb
    begin
        r_clamp = corner_radius_reg;
        if (half_w < r_clamp)
        begin
            r_clamp = half_w;
        end
        if (half_h < r_clamp)
        begin
            r_clamp = half_h;
        end
        dy_full   = {2'b00, pixel.pixel_y} - {rect_top_reg[12], rect_top_reg};
        on_screen = ({1'b0, pixel.pixel_x} < SCREEN_WIDTH)
                 && ({1'b0, pixel.pixel_y} < SCREEN_HEIGHT);
        carry_next.px     = pixel.pixel_x;
        carry_next.dy     = dy_full[12:0];
        carry_next.r      = r_clamp;
        carry_next.row_ok = on_screen && !dy_full[13]
                         && (dy_full[12:0] < rect_height_reg)
                         && (rect_width_reg != '0);
        carry_next.dst    = pixel.dst_pixel;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            carry_reg[0] <= carry_next;
            for (int i = 1; i < CARRY_N; i++)
            begin
                carry_reg[i] <= carry_reg[i-1];
            end
        end
    end

    // ---------------- stage 1: distance into the corner band ----------------
    // Rows outside both bands get t = 0, so the root equals r and the inset is 0.
    logic [12:0] band_lo;
    logic [11:0] t_next;
    logic [11:0] t_reg;

    always_comb
    begin
        band_lo = rect_height_reg - 13'd1 - {1'b0, carry_reg[0].r};
        if (carry_reg[0].dy < {1'b0, carry_reg[0].r})
        begin
            t_next = carry_reg[0].r - carry_reg[0].dy[11:0];
        end
        else if (carry_reg[0].dy > band_lo)
        begin
            t_next = 12'(carry_reg[0].dy - band_lo);
        end
        else
        begin
            t_next = '0;
        end
    end

    // ---------------- stages 2 and 3: r*r - t*t ----------------
    logic [SQ_W-1:0] rr_reg;
    logic [SQ_W-1:0] tt_reg;
    logic [SQ_W-1:0] n_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg  <= t_next;
            rr_reg <= SQ_W'(carry_reg[1].r) * SQ_W'(carry_reg[1].r);
            tt_reg <= SQ_W'(t_reg) * SQ_W'(t_reg);
            n_reg  <= rr_reg - tt_reg;
        end
    end

    // ---------------- stages 4 to 7: square root ----------------
    logic [ROOT_W-1:0] root;

    rraf_isqrt u_isqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (n_reg),
        .root     (root)
    );

    // ---------------- stage 8: row edges ----------------
    logic [11:0]        ins;
    logic signed [15:0] left16;
    logic signed [15:0] right16;
    logic signed [15:0] lo_reg;
    logic signed [15:0] hi_reg;
    logic signed [15:0] slo_reg;
    logic signed [15:0] shi_reg;

    assign ins     = carry_reg[ST_ROOT].r - root;
    assign left16  = {{3{rect_left_reg[12]}}, rect_left_reg};
    assign right16 = left16 + $signed({3'b000, rect_width_reg}) - 16'sd1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg  <= left16  + $signed({4'b0000, ins});
            hi_reg  <= right16 - $signed({4'b0000, ins});
            slo_reg <= left16  + $signed({4'b0000, carry_reg[ST_ROOT].r});
            shi_reg <= right16 - $signed({4'b0000, carry_reg[ST_ROOT].r});
        end
    end

    // ---------------- stage 9: count hits ----------------
    // Border pixels can be hit up to four times; each hit is one blend pass.
    logic signed [15:0] pxs;
    logic               e_left;
    logic               e_right;
    logic               span;
    logic               e_top;
    logic               e_bottom;
    logic [2:0]         hits_next;
    blend_t             bl_reg [BLEND_PASSES+1];

    always_comb
    begin
        pxs      = $signed({4'b0000, carry_reg[ST_EDGE].px});
        e_left   = (pxs == lo_reg);
        e_right  = (pxs == hi_reg);
        span     = (pxs >= slo_reg) && (pxs <= shi_reg);
        e_top    = span && (carry_reg[ST_EDGE].dy == '0);
        e_bottom = span && (carry_reg[ST_EDGE].dy == rect_height_reg - 13'd1);
        if (!carry_reg[ST_EDGE].row_ok || (fill_alpha_reg == '0))
        begin
            hits_next = '0;
        end
        else if (border_mode_reg)
        begin
            hits_next = 3'(e_left) + 3'(e_right) + 3'(e_top) + 3'(e_bottom);
        end
        else
        begin
            hits_next = 3'((pxs >= lo_reg) && (pxs <= hi_reg));
        end
    end

    // ---------------- stages 10 to 13: blend passes ----------------
    // (s*a + d*(255-a)) / 255 with the divide done as (x + (x >> 8) + 1) >> 8
    function automatic logic [7:0] mix_chan(input logic [7:0] d, input logic [15:0] sa,
                                            input logic [7:0] ia);
        logic [15:0] prod;
        logic [16:0] x;
        logic [16:0] q;
        prod = 16'(d) * 16'(ia);
        x    = 17'(sa) + 17'(prod);
        q    = x + 17'(x[16:8]) + 17'd1;
        return q[15:8];
    endfunction

    blend_t bl_next [BLEND_PASSES];

    always_comb
    begin
        for (int p = 0; p < BLEND_PASSES; p++)
        begin
            bl_next[p] = bl_reg[p];
            if (bl_reg[p].hits > 3'(p))
            begin
                if (fill_alpha_reg == 8'd255)
                begin
                    bl_next[p].pix = {8'h00, fill_color_reg};
                end
                else
                begin
                    bl_next[p].pix = {8'h00,
                                      mix_chan(bl_reg[p].pix[23:16], sa_r_reg, ia_reg),
                                      mix_chan(bl_reg[p].pix[15:8],  sa_g_reg, ia_reg),
                                      mix_chan(bl_reg[p].pix[7:0],   sa_b_reg, ia_reg)};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bl_reg[0] <= '{hits: hits_next, pix: carry_reg[ST_EDGE].dst};
            for (int p = 0; p < BLEND_PASSES; p++)
            begin
                bl_reg[p+1] <= bl_next[p];
            end
        end
    end

    // ---------------- output ----------------
    assign result.valid     = vld_reg[LAT-1];
    assign result.new_pixel = bl_reg[BLEND_PASSES].pix;
    assign result.covered   = |bl_reg[BLEND_PASSES].hits;

endmodule

`default_nettype wire
